### rtl/fbc_pkg.sv
package fbc_pkg;

  localparam int COORD_BITS     = 16;
  localparam int COEF_BITS      = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int NUM_PLANES     = 6;
  localparam int NUM_AXES       = 3;
  localparam int NUM_CORNERS    = 8;
  localparam int CFG_DATA_BITS  = 4 * COEF_BITS;
  localparam int CFG_IDX_BITS   = 3;
  localparam int PROD_BITS      = COORD_BITS + COEF_BITS;
  localparam int DSH_BITS       = COEF_BITS + COEF_FRAC_BITS;
  localparam int SUM_BITS       = ((PROD_BITS > DSH_BITS) ? PROD_BITS : DSH_BITS) + 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_NEAR   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_FAR    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_LEFT   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_TOP    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_BOTTOM = 3'd5;

  typedef enum logic [1:0] {
    CONT_DISJOINT   = 2'd0,
    CONT_INTERSECTS = 2'd1,
    CONT_CONTAINS   = 2'd2
  } contain_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  // a in the low bits
  typedef struct packed {
    coef_t d;
    coef_t c;
    coef_t b;
    coef_t a;
  } plane_t;

  typedef struct packed {
    coord_t [NUM_AXES-1:0] hi;
    coord_t [NUM_AXES-1:0] lo;
  } box_t;

  typedef struct packed {
    prod_t hi;
    prod_t lo;
  } prod_pair_t;

  typedef prod_pair_t [NUM_AXES-1:0] plane_prods_t;

endpackage

### rtl/fbc_plane_regs.sv
module fbc_plane_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fbc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [fbc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output fbc_pkg::plane_t                      planes [fbc_pkg::NUM_PLANES]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
        planes[p] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        fbc_pkg::REG_PLANE_NEAR:
          planes[fbc_pkg::REG_PLANE_NEAR] <= fbc_pkg::plane_t'(cfg_data);
        fbc_pkg::REG_PLANE_FAR:
          planes[fbc_pkg::REG_PLANE_FAR] <= fbc_pkg::plane_t'(cfg_data);
        fbc_pkg::REG_PLANE_LEFT:
          planes[fbc_pkg::REG_PLANE_LEFT] <= fbc_pkg::plane_t'(cfg_data);
        fbc_pkg::REG_PLANE_RIGHT:
          planes[fbc_pkg::REG_PLANE_RIGHT] <= fbc_pkg::plane_t'(cfg_data);
        fbc_pkg::REG_PLANE_TOP:
          planes[fbc_pkg::REG_PLANE_TOP] <= fbc_pkg::plane_t'(cfg_data);
        fbc_pkg::REG_PLANE_BOTTOM:
          planes[fbc_pkg::REG_PLANE_BOTTOM] <= fbc_pkg::plane_t'(cfg_data);
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

endmodule

### rtl/fbc_products.sv
module fbc_products (
  input  logic                  clk,
  input  logic                  en,
  input  fbc_pkg::box_t         box,
  input  fbc_pkg::plane_t       planes [fbc_pkg::NUM_PLANES],
  output fbc_pkg::plane_prods_t prods  [fbc_pkg::NUM_PLANES]
);

  fbc_pkg::plane_prods_t prods_next [fbc_pkg::NUM_PLANES];
  fbc_pkg::coef_t        coef       [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];

  // each coefficient times the low and high coordinate of its axis
  always_comb begin
    for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
      coef[p][0] = planes[p].a;
      coef[p][1] = planes[p].b;
      coef[p][2] = planes[p].c;
      for (int k = 0; k < fbc_pkg::NUM_AXES; k++) begin
        prods_next[p][k].lo = fbc_pkg::PROD_BITS'($signed(coef[p][k]))
                            * fbc_pkg::PROD_BITS'($signed(box.lo[k]));
        prods_next[p][k].hi = fbc_pkg::PROD_BITS'($signed(coef[p][k]))
                            * fbc_pkg::PROD_BITS'($signed(box.hi[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prods <= prods_next;
    end
  end

endmodule

### rtl/fbc_classify.sv
module fbc_classify (
  input  fbc_pkg::plane_prods_t prods  [fbc_pkg::NUM_PLANES],
  input  fbc_pkg::plane_t       planes [fbc_pkg::NUM_PLANES],
  output fbc_pkg::contain_t     result
);

  logic signed [fbc_pkg::SUM_BITS-1:0] d_term [fbc_pkg::NUM_PLANES];
  logic signed [fbc_pkg::SUM_BITS-1:0] sum    [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_CORNERS];
  logic signed [fbc_pkg::PROD_BITS-1:0] px, py, pz;
  logic [fbc_pkg::NUM_PLANES-1:0] all_in;
  logic [fbc_pkg::NUM_PLANES-1:0] all_out;
  logic corner_in;

  always_comb begin
    px = '0;
    py = '0;
    pz = '0;
    corner_in = 1'b0;
    for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
      d_term[p]  = fbc_pkg::SUM_BITS'($signed(planes[p].d)) <<< fbc_pkg::COEF_FRAC_BITS;
      all_in[p]  = 1'b1;
      all_out[p] = 1'b1;
      for (int k = 0; k < fbc_pkg::NUM_CORNERS; k++) begin
        // corner bit 0 picks x, bit 1 y, bit 2 z
        px = k[0] ? $signed(prods[p][0].hi) : $signed(prods[p][0].lo);
        py = k[1] ? $signed(prods[p][1].hi) : $signed(prods[p][1].lo);
        pz = k[2] ? $signed(prods[p][2].hi) : $signed(prods[p][2].lo);
        sum[p][k] = fbc_pkg::SUM_BITS'(px) + fbc_pkg::SUM_BITS'(py)
                  + fbc_pkg::SUM_BITS'(pz) + d_term[p];
        // strictly positive only
        corner_in = !sum[p][k][fbc_pkg::SUM_BITS-1] && (|sum[p][k]);
        all_in[p]  = all_in[p] & corner_in;
        all_out[p] = all_out[p] & !corner_in;
      end
    end
    if (|all_out) begin
      result = fbc_pkg::CONT_DISJOINT;
    end else if (!(&all_in)) begin
      result = fbc_pkg::CONT_INTERSECTS;
    end else begin
      result = fbc_pkg::CONT_CONTAINS;
    end
  end

endmodule

### rtl/frustum_box_containment.sv
// Frustum / axis-aligned box classifier. Each beat on the input channel is one
// box (min and max corner, signed integer coordinates); each beat on the output
// channel is its class against the six planes held in the plane registers:
// 0 disjoint, 1 intersects, 2 fully contained. A corner is inside a plane only
// when a*x + b*y + c*z + d*2^14 is strictly above zero, with a, b, c in Q1.14
// and the sum kept exact. Planes are written through cfg_we / cfg_index /
// cfg_data (index 0 near, 1 far, 2 left, 3 right, 4 top, 5 bottom, a in the
// low 16 bits, d in the top 16); writes to indexes 6 and 7 are dropped, and all
// planes reset to zero, which classifies every box as disjoint. Write planes
// only while no box is in flight. The block takes one box per clock unless the
// output stalls; each box passes three registered stages: one registers the
// box, the next registers the 36 coefficient-by-coordinate products (two per
// axis per plane, shared by the eight corners), and the last adds up the 48
// corner sums and registers the class. Output back-pressure stalls the whole
// pipeline, so input ready drops only when all three stages hold a beat.
module frustum_box_containment (
  input  logic                                clk,
  input  logic                                rst,
  // plane registers
  input  logic                                cfg_we,
  input  logic [fbc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fbc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // box beats
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] min_x,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] min_y,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] min_z,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] max_x,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] max_y,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] max_z,
  // result beats
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          containment
);

  fbc_pkg::plane_t       planes [fbc_pkg::NUM_PLANES];
  fbc_pkg::plane_prods_t prods  [fbc_pkg::NUM_PLANES];
  fbc_pkg::box_t         box;
  fbc_pkg::contain_t     class_next;

  logic box_valid;    // input stage holds a beat
  logic prod_valid;   // product stage holds a beat
  logic out_en;
  logic prod_en;
  logic box_en;

  // stage enables: a stage loads when it is empty or its beat moves on
  assign out_en   = !out_valid || out_ready;
  assign prod_en  = !prod_valid || out_en;
  assign box_en   = !box_valid || prod_en;
  assign in_ready = box_en;

  fbc_plane_regs u_plane_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // input register, payload needs no reset
  always_ff @(posedge clk) begin
    if (box_en && in_valid) begin
      box.lo[0] <= min_x;
      box.lo[1] <= min_y;
      box.lo[2] <= min_z;
      box.hi[0] <= max_x;
      box.hi[1] <= max_y;
      box.hi[2] <= max_z;
    end
  end

  fbc_products u_products (
    .clk    (clk),
    .en     (prod_en && box_valid),
    .box    (box),
    .planes (planes),
    .prods  (prods)
  );

  fbc_classify u_classify (
    .prods  (prods),
    .planes (planes),
    .result (class_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_en && prod_valid) begin
      containment <= class_next;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid  <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (box_en) begin
        box_valid <= in_valid;
      end
      if (prod_en) begin
        prod_valid <= box_valid;
      end
      if (out_en) begin
        out_valid <= prod_valid;
      end
    end
  end

endmodule

### rtl/fbc_checker.sv
module fbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] containment
);

  // no result straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown after reset");

  // only the three defined classes ever leave the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (containment == fbc_pkg::CONT_DISJOINT
                || containment == fbc_pkg::CONT_INTERSECTS
                || containment == fbc_pkg::CONT_CONTAINS))
    else $error("undefined containment code");

  // input stalls only when the output side is back-pressured
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(containment)))
    else $error("stalled result beat changed");

endmodule

bind frustum_box_containment fbc_checker u_fbc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .containment (containment)
);

### tb/sv/frustum_box_containment_tb.sv
`timescale 1ns / 100ps

module frustum_box_containment_tb;
  import fbc_pkg::*;

  localparam int CLK_HALF_NS     = 5;
  localparam int RESET_CYCLES    = 4;
  // pipeline is three stages deep, drain margin before touching planes
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 210;
  // far beyond the slowest legal run
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam int CMIN            = -32768;
  localparam int CMAX            = 32767;
  localparam int CUBE_HALF       = 1000;
  localparam int ONE_Q           = 1 << COEF_FRAC_BITS;
  localparam int NUM_IDX         = 1 << CFG_IDX_BITS;
  localparam int NUM_DIRECTED    = 22;

  // which set of planes a stretch of boxes runs against
  typedef enum int {
    SET_RESET,
    SET_CUBE,
    SET_EXTREME,
    SET_FRUSTUM,
    SET_FRUSTUM_ZERO_PLANE,
    SET_RANDOM,
    SET_ALL_ONES,
    SET_POS_MAX,
    SET_NEG_MAX,
    SET_ZERO
  } plane_set_e;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_beat_t;

  // one row of the directed table; verdict only counts where known is set
  typedef struct packed {
    plane_set_e plane_set;
    int         mnx;
    int         mny;
    int         mnz;
    int         mxx;
    int         mxy;
    int         mxz;
    bit         known;
    contain_t   verdict;
  } box_row_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  coord_t                   min_x     = '0;
  coord_t                   min_y     = '0;
  coord_t                   min_z     = '0;
  coord_t                   max_x     = '0;
  coord_t                   max_y     = '0;
  coord_t                   max_z     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               containment;

  // shadow of the plane registers, and the set about to be written
  plane_t   plane_copy  [NUM_PLANES];
  plane_t   next_planes [NUM_PLANES];
  // classes still owed by the block, oldest first
  contain_t expected_class_q [$];

  // box shaping follows the frustum last built
  int ctr [NUM_AXES];
  int half_ext;

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count     = 0;
  int boxes_sent     = 0;
  int settings_count = 0;
  int class_count [3];

  // directed boxes: reset rows are disjoint by construction, the rest go
  // through the predictor
  box_row_t directed_rows [NUM_DIRECTED] = '{
    '{SET_RESET, 0, 0, 0, 0, 0, 0, 1'b1, CONT_DISJOINT},
    '{SET_RESET, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b1, CONT_DISJOINT},
    '{SET_RESET, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b1, CONT_DISJOINT},
    '{SET_RESET, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1, CONT_DISJOINT},
    '{SET_RESET, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b1, CONT_DISJOINT},
    '{SET_CUBE, -10, -10, -10, 10, 10, 10, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, -999, -999, -999, 999, 999, 999, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, -1000, 0, 0, 0, 0, 0, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, -1000, 0, 0, -1000, 0, 0, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, 500, 500, 500, 1500, 1500, 1500, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, 2000, -10, -10, 3000, 10, 10, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, 100, 100, 100, -100, -100, -100, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, 1500, 0, 0, -1500, 0, 0, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0, CONT_DISJOINT},
    '{SET_CUBE, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0, CONT_DISJOINT},
    '{SET_EXTREME, 0, 0, 0, 0, 0, 0, 1'b0, CONT_DISJOINT},
    '{SET_EXTREME, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0, CONT_DISJOINT},
    '{SET_EXTREME, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0, CONT_DISJOINT},
    '{SET_EXTREME, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0, CONT_DISJOINT},
    '{SET_EXTREME, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 1'b0, CONT_DISJOINT},
    '{SET_EXTREME, -1, -1, -1, -1, -1, -1, 1'b0, CONT_DISJOINT}
  };

  // plane settings for the random phases, three phases per idling pattern
  plane_set_e phase_plan [NUM_PHASES] = '{
    SET_FRUSTUM, SET_RANDOM, SET_ALL_ONES,
    SET_FRUSTUM, SET_POS_MAX, SET_FRUSTUM_ZERO_PLANE,
    SET_NEG_MAX, SET_ZERO, SET_FRUSTUM
  };

  frustum_box_containment uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .min_x       (min_x),
    .min_y       (min_y),
    .min_z       (min_z),
    .max_x       (max_x),
    .max_y       (max_y),
    .max_z       (max_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .containment (containment)
  );

  always #CLK_HALF_NS clk = ~clk;

  // class of one box against the shadow planes; sums are exact in 64 bits
  function automatic contain_t classify_box(box_beat_t bx);
    int       p;
    int       k;
    longint   x;
    longint   y;
    longint   z;
    longint   sum;
    bit       any_in;
    bit       any_out;
    plane_t   pl;
    contain_t cls;
    cls = CONT_CONTAINS;
    for (p = 0; p < NUM_PLANES; p++) begin
      pl      = plane_copy[p];
      any_in  = 1'b0;
      any_out = 1'b0;
      for (k = 0; k < NUM_CORNERS; k++) begin
        x = k[0] ? longint'($signed(bx.max_x)) : longint'($signed(bx.min_x));
        y = k[1] ? longint'($signed(bx.max_y)) : longint'($signed(bx.min_y));
        z = k[2] ? longint'($signed(bx.max_z)) : longint'($signed(bx.min_z));
        sum = longint'($signed(pl.a)) * x + longint'($signed(pl.b)) * y
            + longint'($signed(pl.c)) * z + longint'($signed(pl.d)) * longint'(ONE_Q);
        // a corner sitting exactly on the plane counts as outside
        if (sum > 0) begin
          any_in = 1'b1;
        end else begin
          any_out = 1'b1;
        end
      end
      // every corner behind one plane settles it
      if (!any_in) return CONT_DISJOINT;
      if (any_out) cls = CONT_INTERSECTS;
    end
    return cls;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // six planes around a box of half size h; tilt perturbs the normals
  task automatic build_frustum(int cx, int cy, int cz, int h, bit tilt);
    int p;
    int i;
    int ax;
    int sgn;
    int m;
    int dot;
    int d;
    int n [NUM_AXES];
    ctr[0]   = cx;
    ctr[1]   = cy;
    ctr[2]   = cz;
    half_ext = h;
    for (p = 0; p < NUM_PLANES; p++) begin
      // near/far on z, left/right on x, top/bottom on y
      ax  = (p / 2 + 2) % NUM_AXES;
      sgn = p[0] ? -1 : 1;
      m   = tilt ? rand_between(12000, ONE_Q) : ONE_Q;
      for (i = 0; i < NUM_AXES; i++) begin
        n[i] = (i == ax) ? sgn * m : (tilt ? rand_between(-2000, 2000) : 0);
      end
      dot = n[0] * cx + n[1] * cy + n[2] * cz;
      d   = (m * h - dot) / ONE_Q;
      next_planes[p].a = coef_t'(n[0]);
      next_planes[p].b = coef_t'(n[1]);
      next_planes[p].c = coef_t'(n[2]);
      next_planes[p].d = coef_t'(d);
    end
  endtask

  // fill next_planes, then write all indexes back to back, the two unused
  // ones with junk that must be dropped
  task automatic load_plane_set(plane_set_e kind);
    int                       i;
    logic [CFG_DATA_BITS-1:0] word;
    case (kind)
      SET_CUBE: begin
        build_frustum(0, 0, 0, CUBE_HALF, 1'b0);
      end
      SET_FRUSTUM, SET_FRUSTUM_ZERO_PLANE: begin
        build_frustum(rand_between(-4000, 4000), rand_between(-4000, 4000),
                      rand_between(-4000, 4000), rand_between(500, 8000), 1'b1);
        // one all-zero plane throws every box out
        if (kind == SET_FRUSTUM_ZERO_PLANE) begin
          next_planes[$urandom_range(NUM_PLANES - 1)] = '0;
        end
      end
      SET_EXTREME: begin
        next_planes[REG_PLANE_NEAR]   = {4{16'h8000}};
        next_planes[REG_PLANE_FAR]    = {4{16'h7fff}};
        next_planes[REG_PLANE_LEFT]   = '1;
        next_planes[REG_PLANE_RIGHT]  = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
        next_planes[REG_PLANE_TOP]    = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        next_planes[REG_PLANE_BOTTOM] = {16'h0000, 16'h0001, 16'hffff, 16'h0001};
      end
      SET_RANDOM: begin
        for (i = 0; i < NUM_PLANES; i++) next_planes[i] = {$urandom, $urandom};
      end
      SET_ALL_ONES: begin
        for (i = 0; i < NUM_PLANES; i++) next_planes[i] = '1;
      end
      SET_POS_MAX: begin
        for (i = 0; i < NUM_PLANES; i++) next_planes[i] = {4{16'h7fff}};
      end
      SET_NEG_MAX: begin
        for (i = 0; i < NUM_PLANES; i++) next_planes[i] = {4{16'h8000}};
      end
      default: begin
        for (i = 0; i < NUM_PLANES; i++) next_planes[i] = '0;
      end
    endcase
    for (i = REG_PLANE_NEAR; i < NUM_IDX; i++) begin
      word = (i <= REG_PLANE_BOTTOM) ? CFG_DATA_BITS'(next_planes[i]) : {$urandom, $urandom};
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      cfg_data  <= word;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    for (i = 0; i < NUM_PLANES; i++) plane_copy[i] = next_planes[i];
    settings_count++;
  endtask

  // drop valid and let the pipeline empty before the planes change
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_class_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one box beat: random gaps first, then hold until accepted
  task automatic send_box(box_beat_t bx, bit known, contain_t known_class);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    min_x    <= bx.min_x;
    min_y    <= bx.min_y;
    min_z    <= bx.min_z;
    max_x    <= bx.max_x;
    max_y    <= bx.max_y;
    max_z    <= bx.max_z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_class_q.push_back(known ? known_class : classify_box(bx));
    boxes_sent++;
  endtask

  // result side: random back-pressure, compare every beat taken
  always @(posedge clk) begin : result_check
    contain_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (containment <= CONT_CONTAINS) class_count[containment]++;
        if (expected_class_q.size() == 0) begin
          $error("containment: result beat with nothing expected, actual %0d", containment);
          fail_count++;
        end else begin
          want = expected_class_q.pop_front();
          if (containment !== want) begin
            $error("containment mismatch: expected %0d, actual %0d", want, containment);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    int         i;
    int         p;
    int         ax;
    int         r;
    int         h;
    int         sgn;
    int         tmp;
    int         lo_c [NUM_AXES];
    int         hi_c [NUM_AXES];
    box_beat_t  bx;
    box_row_t   row;
    plane_set_e current_set;

    for (i = 0; i < NUM_PLANES; i++) plane_copy[i] = '0;
    for (i = 0; i < 3; i++) class_count[i] = 0;
    ctr[0]        = 0;
    ctr[1]        = 0;
    ctr[2]        = 0;
    half_ext      = CUBE_HALF;
    // sender mostly busy, receiver mostly stalled to start with
    send_idle_pct = 6;
    recv_idle_pct = 86;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table: reset planes first, then the cube, then extremes
    current_set = SET_RESET;
    for (i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.plane_set != current_set) begin
        wait_idle();
        load_plane_set(row.plane_set);
        current_set = row.plane_set;
      end
      bx.min_x = coord_t'(row.mnx);
      bx.min_y = coord_t'(row.mny);
      bx.min_z = coord_t'(row.mnz);
      bx.max_x = coord_t'(row.mxx);
      bx.max_y = coord_t'(row.mxy);
      bx.max_z = coord_t'(row.mxz);
      send_box(bx, row.known, row.verdict);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      // idling pattern swaps after three phases, then switches off
      case (p / 3)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_idle();
      load_plane_set(phase_plan[p]);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(99);
        h = half_ext;
        if (r < 15) begin
          // raw bits, every coordinate bit gets toggled
          bx = {$urandom, $urandom, $urandom};
        end else begin
          for (ax = 0; ax < NUM_AXES; ax++) begin
            if (r < 60) begin
              // well inside, or inverted on some axes
              lo_c[ax] = rand_between(ctr[ax] - h / 2, ctr[ax] + h / 2);
              hi_c[ax] = lo_c[ax] + rand_between(0, h / 3);
              if (r < 25 && $urandom_range(1)) begin
                tmp      = lo_c[ax];
                lo_c[ax] = hi_c[ax];
                hi_c[ax] = tmp;
              end
            end else if (r < 85) begin
              // straddling the walls
              lo_c[ax] = rand_between(ctr[ax] - h - h / 4, ctr[ax] + h);
              hi_c[ax] = lo_c[ax] + rand_between(h / 8, h / 2);
            end else begin
              // clear of the frustum
              sgn      = $urandom_range(1) ? 1 : -1;
              lo_c[ax] = ctr[ax] + sgn * (h + rand_between(h / 8, h));
              hi_c[ax] = lo_c[ax] + rand_between(0, h / 4);
            end
          end
          bx.min_x = coord_t'(lo_c[0]);
          bx.min_y = coord_t'(lo_c[1]);
          bx.min_z = coord_t'(lo_c[2]);
          bx.max_x = coord_t'(hi_c[0]);
          bx.max_y = coord_t'(hi_c[1]);
          bx.max_z = coord_t'(hi_c[2]);
        end
        send_box(bx, 1'b0, CONT_DISJOINT);
      end
    end

    wait_idle();
    $display("%0d boxes classified over %0d plane settings, unused indexes written each time",
             boxes_sent, settings_count);
    $display("results seen: %0d disjoint, %0d intersecting, %0d contained",
             class_count[CONT_DISJOINT], class_count[CONT_INTERSECTS],
             class_count[CONT_CONTAINS]);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hung handshake guard
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
rtl/fbc_pkg.sv
rtl/fbc_plane_regs.sv
rtl/fbc_products.sv
rtl/fbc_classify.sv
rtl/frustum_box_containment.sv
rtl/fbc_checker.sv
tb/sv/frustum_box_containment_tb.sv
